// File: hdl/fbpa_pkg.sv
// Shared constants, types and helper functions of the fixed block pool allocator.
// Used by fbpa_div, fbpa_map and the top level; depends on nothing else.
`timescale 1ns / 1ps

package fbpa_pkg;

   localparam int MAX_BLOCKS  = 4096;
   localparam int ADDR_W      = 48;
   localparam int BYTES_W     = 32;
   localparam int COUNT_W     = 13;
   localparam int CSR_W       = 48;
   localparam int CSR_IDX_W   = 2;

   localparam int WORD_W      = 32;
   localparam int WORD_IDX_W  = $clog2(WORD_W);
   localparam int MAP_ROWS    = MAX_BLOCKS / WORD_W;
   localparam int ROW_W       = $clog2(MAP_ROWS);
   localparam int INDEX_W     = $clog2(MAX_BLOCKS);

   localparam int SCAN_BITS   = 16;
   localparam int SCAN_IDX_W  = $clog2(SCAN_BITS);
   localparam int SCAN_STEPS  = MAP_ROWS / SCAN_BITS;
   localparam int SCAN_W      = $clog2(SCAN_STEPS);

   localparam int DIV_CNT_W   = $clog2(ADDR_W + 1);

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] ST_OK           = 2'd0;
   localparam logic [1:0] ST_EXHAUSTED    = 2'd1;
   localparam logic [1:0] ST_NOT_BLOCK    = 2'd2;
   localparam logic [1:0] ST_ALREADY_FREE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT = 2'd2;

   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [ROW_W-1:0]  row;
      logic [WORD_W-1:0] wdata;
   } map_cmd_type;

   typedef struct packed {
      logic               start;
      logic [ADDR_W-1:0]  dividend;
      logic [BYTES_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [ADDR_W-1:0]  quotient;
      logic [BYTES_W-1:0] remainder;
   } div_rsp_type;

   function automatic logic [SCAN_IDX_W-1:0] lowest_set16(input logic [SCAN_BITS-1:0] v);
      logic [SCAN_IDX_W-1:0] pos;
      pos = '0;
      for (int i = SCAN_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            pos = SCAN_IDX_W'(i);
         end
      end
      return pos;
   endfunction

   function automatic logic [WORD_IDX_W-1:0] lowest_set32(input logic [WORD_W-1:0] v);
      logic [WORD_IDX_W-1:0] pos;
      pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (v[i]) begin
            pos = WORD_IDX_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

// File: hdl/fbpa_div.sv
// Restoring divider, one quotient bit per cycle, for the allocator's pool-fit division and address checks.
// Depends on fbpa_pkg.
`timescale 1ns / 1ps

module fbpa_div (
   input  logic                  clock,
   input  logic                  reset,
   input  fbpa_pkg::div_req_type req,
   output fbpa_pkg::div_rsp_type rsp
);
   import fbpa_pkg::*;

   logic [ADDR_W-1:0]    quo_ff, quo_in;
   logic [BYTES_W-1:0]   rem_ff, rem_in;
   logic [BYTES_W-1:0]   dsr_ff, dsr_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [BYTES_W:0]     trial;
   logic [BYTES_W:0]     diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[ADDR_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         dsr_in  = req.divisor;
         cnt_in  = DIV_CNT_W'(ADDR_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[BYTES_W-1:0];
            quo_in = {quo_ff[ADDR_W-2:0], 1'b1};
         end else begin
            rem_in = trial[BYTES_W-1:0];
            quo_in = {quo_ff[ADDR_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

// File: hdl/fbpa_map.sv
// Free map store: one bit per block in a word-wide synchronous memory, with per-row
// valid bits (unwritten rows read as all free) and a per-row any-free summary.
// Depends on fbpa_pkg.
`timescale 1ns / 1ps

module fbpa_map (
   input  logic                          clock,
   input  logic                          reset,
   input  fbpa_pkg::map_cmd_type         cmd,
   output logic [fbpa_pkg::WORD_W-1:0]   rd_word,
   output logic [fbpa_pkg::MAP_ROWS-1:0] summary
);
   import fbpa_pkg::*;

   logic [WORD_W-1:0]   mem [MAP_ROWS];
   logic [WORD_W-1:0]   rd_data_ff;
   logic                rd_valid_ff, rd_valid_in;
   logic [MAP_ROWS-1:0] row_valid_ff, row_valid_in;
   logic [MAP_ROWS-1:0] summary_ff, summary_in;

   always_comb begin
      row_valid_in = row_valid_ff;
      summary_in   = summary_ff;
      rd_valid_in  = rd_valid_ff;
      if (cmd.wr_en) begin
         row_valid_in[cmd.row] = 1'b1;
         summary_in[cmd.row]   = |cmd.wdata;
      end
      if (cmd.rd_en) begin
         rd_valid_in = row_valid_ff[cmd.row];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         summary_ff   <= '1;
         rd_valid_ff  <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         summary_ff   <= summary_in;
         rd_valid_ff  <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.row] <= cmd.wdata;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.row];
      end
   end

   assign rd_word = rd_valid_ff ? rd_data_ff : '1;
   assign summary = summary_ff;

endmodule

// File: hdl/fixed_block_pool_allocator.sv
// Fixed block pool allocator: first-fit allocate and checked free over a bitmap store.
// One item at a time. Allocate runs a summary scan of 16 rows per cycle, one map read,
// a multiply and an add; free runs the 48-step divider and a map read. After a register
// write the next item first waits for the pool-fit division. Reset (synchronous)
// restores the register defaults and marks every block free at once through per-row
// valid bits; no clearing pass is needed.
`timescale 1ns / 1ps

module fixed_block_pool_allocator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [fbpa_pkg::ADDR_W-1:0]      req_tdata,  // address
   input  logic                             req_tuser,  // command
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [63:0]                      rsp_tdata,  // block_address, free_blocks
   output logic [1:0]                       rsp_tuser,  // status
   input  logic                             csr_wr_en,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fbpa_pkg::CSR_W-1:0]       csr_wdata
);
   import fbpa_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_FIT      = 4'd1;
   localparam logic [3:0] S_DISPATCH = 4'd2;
   localparam logic [3:0] S_SCAN     = 4'd3;
   localparam logic [3:0] S_AREAD    = 4'd4;
   localparam logic [3:0] S_AMUL     = 4'd5;
   localparam logic [3:0] S_AADD     = 4'd6;
   localparam logic [3:0] S_FDIV     = 4'd7;
   localparam logic [3:0] S_FREAD    = 4'd8;
   localparam logic [3:0] S_RESP     = 4'd9;

   logic [3:0]                 state_ff, state_in;
   logic [ADDR_W-1:0]          base_ff, base_in;
   logic [BYTES_W-1:0]         bytes_ff, bytes_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic                       dirty_ff, dirty_in;
   logic [COUNT_W-1:0]         used_ff, used_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic [COUNT_W-1:0]         pool_n_ff, pool_n_in;
   logic                       cmd_ff, cmd_in;
   logic [ADDR_W-1:0]          addr_ff, addr_in;
   logic [SCAN_W-1:0]          chunk_ff, chunk_in;
   logic [ROW_W-1:0]           row_ff, row_in;
   logic [INDEX_W-1:0]         idx_ff, idx_in;
   logic [INDEX_W+BYTES_W-1:0] prod_ff, prod_in;
   logic [1:0]                 status_ff, status_in;
   logic [ADDR_W-1:0]          res_addr_ff, res_addr_in;
   logic [1:0]                 rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]          rsp_addr_ff, rsp_addr_in;
   logic [COUNT_W-1:0]         rsp_free_ff, rsp_free_in;

   logic [BYTES_W-1:0]         eff_bytes;
   logic [COUNT_W-1:0]         sat_count;
   logic [SCAN_BITS-1:0]       chunk_bits;
   logic [WORD_IDX_W-1:0]      bit_sel;
   logic [INDEX_W-1:0]         idx_new;
   logic [COUNT_W-1:0]         free_now;

   map_cmd_type                map_cmd;
   logic [WORD_W-1:0]          map_word;
   logic [MAP_ROWS-1:0]        summary;
   div_req_type                div_req;
   div_rsp_type                div_rsp;

   fbpa_map u_map (
      .clock   (clock),
      .reset   (reset),
      .cmd     (map_cmd),
      .rd_word (map_word),
      .summary (summary)
   );

   fbpa_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign eff_bytes  = (bytes_ff == '0) ? BYTES_W'(1) : bytes_ff;
   assign sat_count  = (count_ff > COUNT_W'(MAX_BLOCKS)) ? COUNT_W'(MAX_BLOCKS) : count_ff;
   assign chunk_bits = summary[chunk_ff*SCAN_BITS +: SCAN_BITS];
   assign bit_sel    = lowest_set32(map_word);
   assign idx_new    = {row_ff, bit_sel};
   assign free_now   = (pool_n_ff > used_ff) ? (pool_n_ff - used_ff) : '0;

   always_comb begin
      state_in      = state_ff;
      base_in       = base_ff;
      bytes_in      = bytes_ff;
      count_in      = count_ff;
      dirty_in      = dirty_ff;
      used_in       = used_ff;
      rsp_valid_in  = rsp_valid_ff;
      pool_n_in     = pool_n_ff;
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      chunk_in      = chunk_ff;
      row_in        = row_ff;
      idx_in        = idx_ff;
      prod_in       = prod_ff;
      status_in     = status_ff;
      res_addr_in   = res_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_free_in   = rsp_free_ff;
      map_cmd       = '0;
      div_req.start    = 1'b0;
      div_req.dividend = '1 - base_ff;
      div_req.divisor  = eff_bytes;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in  = req_tuser;
               addr_in = req_tdata;
               if (dirty_ff) begin
                  div_req.start = 1'b1;
                  state_in      = S_FIT;
               end else begin
                  state_in = S_DISPATCH;
               end
            end
         end
         S_FIT: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient >= ADDR_W'(sat_count)) begin
                  pool_n_in = sat_count;
               end else begin
                  pool_n_in = div_rsp.quotient[COUNT_W-1:0] + 1'b1;
               end
               dirty_in = 1'b0;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            res_addr_in = '0;
            status_in   = ST_OK;
            if (cmd_ff == CMD_ALLOC) begin
               chunk_in = '0;
               state_in = S_SCAN;
            end else if (addr_ff < base_ff) begin
               status_in = ST_NOT_BLOCK;
               state_in  = S_RESP;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = addr_ff - base_ff;
               state_in         = S_FDIV;
            end
         end
         S_SCAN: begin
            if (|chunk_bits) begin
               row_in        = {chunk_ff, lowest_set16(chunk_bits)};
               map_cmd.rd_en = 1'b1;
               map_cmd.row   = {chunk_ff, lowest_set16(chunk_bits)};
               state_in      = S_AREAD;
            end else if (chunk_ff == SCAN_W'(SCAN_STEPS - 1)) begin
               status_in = ST_EXHAUSTED;
               state_in  = S_RESP;
            end else begin
               chunk_in = chunk_ff + 1'b1;
            end
         end
         S_AREAD: begin
            if ({1'b0, idx_new} >= pool_n_ff) begin
               status_in = ST_EXHAUSTED;
               state_in  = S_RESP;
            end else begin
               map_cmd.wr_en = 1'b1;
               map_cmd.row   = row_ff;
               map_cmd.wdata = map_word & ~(WORD_W'(1) << bit_sel);
               used_in       = used_ff + 1'b1;
               idx_in        = idx_new;
               state_in      = S_AMUL;
            end
         end
         S_AMUL: begin
            prod_in  = {{BYTES_W{1'b0}}, idx_ff} * {{INDEX_W{1'b0}}, eff_bytes};
            state_in = S_AADD;
         end
         S_AADD: begin
            res_addr_in = base_ff + ADDR_W'(prod_ff);
            state_in    = S_RESP;
         end
         S_FDIV: begin
            if (div_rsp.done) begin
               if (div_rsp.remainder != '0 ||
                   div_rsp.quotient >= ADDR_W'(pool_n_ff)) begin
                  status_in = ST_NOT_BLOCK;
                  state_in  = S_RESP;
               end else begin
                  idx_in        = div_rsp.quotient[INDEX_W-1:0];
                  map_cmd.rd_en = 1'b1;
                  map_cmd.row   = div_rsp.quotient[INDEX_W-1:WORD_IDX_W];
                  state_in      = S_FREAD;
               end
            end
         end
         S_FREAD: begin
            if (map_word[idx_ff[WORD_IDX_W-1:0]]) begin
               status_in = ST_ALREADY_FREE;
            end else begin
               map_cmd.wr_en = 1'b1;
               map_cmd.row   = idx_ff[INDEX_W-1:WORD_IDX_W];
               map_cmd.wdata = map_word | (WORD_W'(1) << idx_ff[WORD_IDX_W-1:0]);
               if (used_ff != '0) begin
                  used_in = used_ff - 1'b1;
               end
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_addr_in   = res_addr_ff;
               rsp_free_in   = free_now;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         case (csr_index)
            CSR_BASE: begin
               base_in  = csr_wdata[ADDR_W-1:0];
               dirty_in = 1'b1;
            end
            CSR_BYTES: begin
               bytes_in = csr_wdata[BYTES_W-1:0];
               dirty_in = 1'b1;
            end
            CSR_COUNT: begin
               count_in = csr_wdata[COUNT_W-1:0];
               dirty_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= '0;
         bytes_ff     <= BYTES_W'(4096);
         count_ff     <= COUNT_W'(4096);
         dirty_ff     <= 1'b1;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         bytes_ff     <= bytes_in;
         count_ff     <= count_in;
         dirty_ff     <= dirty_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pool_n_ff     <= pool_n_in;
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      chunk_ff      <= chunk_in;
      row_ff        <= row_in;
      idx_ff        <= idx_in;
      prod_ff       <= prod_in;
      status_ff     <= status_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(64 - ADDR_W - COUNT_W){1'b0}}, rsp_free_ff, rsp_addr_ff};

endmodule
